@@ src/pdtm_pkg.sv @@
package pdtm_pkg;

    // Opcodes carried in the input tuser
    localparam logic [1:0] OP_TICK = 2'd0;
    localparam logic [1:0] OP_LOAD = 2'd1;
    localparam logic [1:0] OP_ON   = 2'd2;
    localparam logic [1:0] OP_OFF  = 2'd3;

    // Configuration register indexes
    localparam logic CFG_AMPLITUDE = 1'b0;
    localparam logic CFG_REL_STEP  = 1'b1;

    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint          ONE_Q30     = 64'sd1073741824;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DEC,
        S_RD,
        S_MUL,
        S_LUT,
        S_M2,
        S_M3,
        S_M4,
        S_ACC,
        S_DONE,
        S_ORD,
        S_OWR
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic capture;
        logic clr_acc;
        logic rd_op;
        logic mul;
        logic lut;
        logic m2;
        logic m3;
        logic m4;
        logic acc_wr;
        logic op_wr;
        logic out_load;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic [1:0] op;
        logic       voice_ok;
    } t_stat;

    function automatic longint clamp_q30(input longint v);
        longint r;
        r = v;
        if (v < 0) r = 0;
        else if (v > ONE_Q30) r = ONE_Q30;
        return r;
    endfunction

    // cos of j quarter-wave steps, Q15, truncated Taylor series
    // Term n is divided by (2n-1)*(2n), odd terms subtract
    function automatic int quarter_cos(input int j, input int tb);
        longint unsigned a;
        longint unsigned a2;
        longint unsigned term;
        longint          sum;
        a    = (longint'(j) * HALF_PI_Q30) >> (tb - 2);
        a2   = (a * a) >> 30;
        term = ONE_Q30;
        sum  = ONE_Q30;
        term = ((term * a2) >> 30) / 64'd2;
        sum  = sum - longint'(term);
        term = ((term * a2) >> 30) / 64'd12;
        sum  = sum + longint'(term);
        term = ((term * a2) >> 30) / 64'd30;
        sum  = sum - longint'(term);
        term = ((term * a2) >> 30) / 64'd56;
        sum  = sum + longint'(term);
        term = ((term * a2) >> 30) / 64'd90;
        sum  = sum - longint'(term);
        term = ((term * a2) >> 30) / 64'd132;
        sum  = sum + longint'(term);
        term = ((term * a2) >> 30) / 64'd182;
        sum  = sum - longint'(term);
        term = ((term * a2) >> 30) / 64'd240;
        sum  = sum + longint'(term);
        sum = clamp_q30(sum);
        return int'((sum + 16384) >>> 15);
    endfunction

    function automatic int cos_entry(input int k, input int tb);
        int quad;
        int r;
        int q;
        int c;
        q    = 1 << (tb - 2);
        quad = k >> (tb - 2);
        r    = k & (q - 1);
        unique case (quad)
            0:       c = quarter_cos(r, tb);
            1:       c = -quarter_cos(q - r, tb);
            2:       c = -quarter_cos(r, tb);
            default: c = quarter_cos(q - r, tb);
        endcase
        return c;
    endfunction

    // exp(-rate*k/2^tb) in Q30: series at 1/64 of the argument, squared six times
    // Term n is divided by n, odd terms subtract
    function automatic longint unsigned exp_entry(input int rate, input int k, input int tb);
        longint unsigned y;
        longint unsigned t;
        longint unsigned term;
        longint          sum;
        longint unsigned v;
        int              n;
        y    = ((longint'(rate) * longint'(k)) << 30) >> tb;
        t    = y >> 6;
        term = ONE_Q30;
        sum  = ONE_Q30;
        term = (term * t) >> 30;
        sum  = sum - longint'(term);
        term = ((term * t) >> 30) / 64'd2;
        sum  = sum + longint'(term);
        term = ((term * t) >> 30) / 64'd3;
        sum  = sum - longint'(term);
        term = ((term * t) >> 30) / 64'd4;
        sum  = sum + longint'(term);
        term = ((term * t) >> 30) / 64'd5;
        sum  = sum - longint'(term);
        term = ((term * t) >> 30) / 64'd6;
        sum  = sum + longint'(term);
        term = ((term * t) >> 30) / 64'd7;
        sum  = sum - longint'(term);
        term = ((term * t) >> 30) / 64'd8;
        sum  = sum + longint'(term);
        term = ((term * t) >> 30) / 64'd9;
        sum  = sum - longint'(term);
        term = ((term * t) >> 30) / 64'd10;
        sum  = sum + longint'(term);
        v = clamp_q30(sum);
        for (n = 0; n < 6; n++) v = (v * v) >> 30;
        return v;
    endfunction

endpackage

@@ src/polyphonic_decaying_tone_mixer.sv @@
// Polyphonic decaying tone mixer.
// Input stream (i_s_*): one transaction per command. tuser is the opcode:
// sample tick, load voice, note on or note off. A tick returns one mixed
// sample on the output stream (o_m_*); the other commands return nothing.
// Commands to a voice index beyond the table are dropped.
// Configuration channel (i_cfg_*): index 0 sets the voice amplitude,
// index 1 the per-sample release step; always ready, write only when idle.
// Timing: a tick walks the voice table one voice at a time, in seven steps per
// voice (table read, two multiplies, table lookup, three products, add and
// write back); the sum is loaded into the output register once that is free,
// and the next command can be taken in the cycle the result becomes valid.
// Load, note on and note off decode, read the voice record and write it back.
// One command is in work at a time; the next is taken once it finishes.
// The result sits in an output register; a stalled receiver holds the
// block only when a second result is ready before the first is taken.
// Reset: voices silent, lengths all ones, tables are constants, configuration
// and control registers back to their defaults. No clearing pass is needed.
module polyphonic_decaying_tone_mixer #(
    parameter int NUM_VOICES  = 16,
    parameter int LENGTH_BITS = 24,
    parameter int TABLE_BITS  = 10
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [1:0]   i_s_tuser,   // opcode
    // voice[3:0], phase_step[35:4], note_length[59:36],
    // inverse_length[91:60], release_level[107:92]
    input  logic [111:0] i_s_tdata,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [31:0]  o_m_tdata,   // sample
    output logic         o_m_tuser,   // clipped
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic         i_cfg_index,
    input  logic [30:0]  i_cfg_data
);
    import pdtm_pkg::*;

    localparam int VW = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;

    t_cmd          w_cmd;
    t_stat         w_stat;
    logic [VW-1:0] w_vidx;

    assign o_cfg_ready = 1'b1;

    pdtm_ctrl #(.NUM_VOICES(NUM_VOICES)) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_tvalid),
        .o_in_ready (o_s_tready),
        .o_out_valid(o_m_tvalid),
        .i_out_ready(i_m_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd),
        .o_vidx     (w_vidx)
    );

    pdtm_dp #(
        .NUM_VOICES (NUM_VOICES),
        .LENGTH_BITS(LENGTH_BITS),
        .TABLE_BITS (TABLE_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat),
        .i_vidx          (w_vidx),
        .i_opcode        (i_s_tuser),
        .i_voice         (i_s_tdata[3:0]),
        .i_phase_step    (i_s_tdata[35:4]),
        .i_note_length   (i_s_tdata[59:36]),
        .i_inverse_length(i_s_tdata[91:60]),
        .i_release_level (i_s_tdata[107:92]),
        .i_cfg_we        (i_cfg_valid && o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_sample        (o_m_tdata),
        .o_clipped       (o_m_tuser)
    );

`ifndef SYNTHESIS
    // One command at a time: no new transaction right after one is taken
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("input accepted twice in a row");

    // A result appears only at the end of a tick, while input is held off
    a_result_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(!o_s_tready))
        else $error("result raised outside a tick");

    // No result rises just after the decode state of an accepted transaction
    a_min_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> ##1 !$rose(o_m_tvalid))
        else $error("result too early after a transaction");
`endif

endmodule

@@ src/pdtm_ram.sv @@
module pdtm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // One write port, registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

@@ src/pdtm_ctrl.sv @@
module pdtm_ctrl #(
    parameter int NUM_VOICES = 16
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       i_in_valid,
    output logic                                       o_in_ready,
    output logic                                       o_out_valid,
    input  logic                                       i_out_ready,
    input  pdtm_pkg::t_stat                            i_stat,
    output pdtm_pkg::t_cmd                             o_cmd,
    output logic [((NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1)-1:0] o_vidx
);
    import pdtm_pkg::*;

    localparam int VW = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;

    t_state          r_state, n_state;
    logic [VW-1:0]   r_vidx, n_vidx;
    logic            r_out_valid, n_out_valid;
    logic            w_last;
    logic            w_out_free;

    assign w_last     = (r_vidx == VW'(NUM_VOICES - 1));
    assign w_out_free = !r_out_valid || i_out_ready;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_in_valid) n_state = S_DEC;
            S_DEC: begin
                if (i_stat.op == OP_TICK) n_state = S_RD;
                else if (i_stat.voice_ok) n_state = S_ORD;
                else n_state = S_IDLE;
            end
            S_RD:   n_state = S_MUL;
            S_MUL:  n_state = S_LUT;
            S_LUT:  n_state = S_M2;
            S_M2:   n_state = S_M3;
            S_M3:   n_state = S_M4;
            S_M4:   n_state = S_ACC;
            S_ACC:  n_state = w_last ? S_DONE : S_RD;
            S_DONE: if (w_out_free) n_state = S_IDLE;
            S_ORD:  n_state = S_OWR;
            S_OWR:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready  = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            S_DEC:  o_cmd.clr_acc = 1'b1;
            S_MUL:  o_cmd.mul = 1'b1;
            S_LUT:  o_cmd.lut = 1'b1;
            S_M2:   o_cmd.m2 = 1'b1;
            S_M3:   o_cmd.m3 = 1'b1;
            S_M4:   o_cmd.m4 = 1'b1;
            S_ACC:  o_cmd.acc_wr = 1'b1;
            S_DONE: o_cmd.out_load = w_out_free;
            S_ORD:  o_cmd.rd_op = 1'b1;
            S_OWR:  o_cmd.op_wr = 1'b1;
            default: o_cmd = '0;
        endcase
    end

    // Voice counter and output valid
    always_comb begin
        n_vidx = r_vidx;
        if (r_state == S_DEC) n_vidx = '0;
        else if (r_state == S_ACC && !w_last) n_vidx = r_vidx + VW'(1);
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) n_out_valid = 1'b1;
        else if (i_out_ready) n_out_valid = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_vidx      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_vidx      <= n_vidx;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_vidx      = r_vidx;
    assign o_out_valid = r_out_valid;

endmodule

@@ src/pdtm_dp.sv @@
module pdtm_dp #(
    parameter int NUM_VOICES  = 16,
    parameter int LENGTH_BITS = 24,
    parameter int TABLE_BITS  = 10
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  pdtm_pkg::t_cmd                             i_cmd,
    output pdtm_pkg::t_stat                            o_stat,
    input  logic [((NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1)-1:0] i_vidx,
    input  logic [1:0]                                 i_opcode,
    input  logic [3:0]                                 i_voice,
    input  logic [31:0]                                i_phase_step,
    input  logic [23:0]                                i_note_length,
    input  logic [31:0]                                i_inverse_length,
    input  logic [15:0]                                i_release_level,
    input  logic                                       i_cfg_we,
    input  logic                                       i_cfg_index,
    input  logic [30:0]                                i_cfg_data,
    output logic [31:0]                                o_sample,
    output logic                                       o_clipped
);
    import pdtm_pkg::*;

    localparam int VW = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
    localparam int XW = (VW > 4) ? VW : 4;
    localparam int TS = 1 << TABLE_BITS;
    localparam int PW = LENGTH_BITS + 32;
    localparam int AW = 33 + $clog2(NUM_VOICES);

    typedef struct packed {
        logic                   active;
        logic [LENGTH_BITS-1:0] pos;
        logic [15:0]            gain;
        logic [31:0]            step;
        logic [LENGTH_BITS-1:0] len;
        logic [31:0]            inv;
    } t_voice;

    localparam int RW = $bits(t_voice);
    localparam t_voice VOICE_RST = '{
        active: 1'b0, pos: {LENGTH_BITS{1'b0}}, gain: 16'h0, step: 32'h0,
        len: {LENGTH_BITS{1'b1}}, inv: 32'h0
    };

    // Cosine (Q15) and decay (Q30) tables, folded to constants
    logic signed [16:0] w_cos_rom [TS];
    logic [30:0]        w_e14_rom [TS];
    logic [30:0]        w_e20_rom [TS];

    for (genvar k = 0; k < TS; k++) begin : g_rom
        assign w_cos_rom[k] = 17'(cos_entry(k, TABLE_BITS));
        assign w_e14_rom[k] = 31'(exp_entry(14, k, TABLE_BITS));
        assign w_e20_rom[k] = 31'(exp_entry(20, k, TABLE_BITS));
    end

    // Captured input item and configuration
    logic [1:0]  r_op;
    logic [3:0]  r_voice;
    logic [31:0] r_step_in;
    logic [23:0] r_len_in;
    logic [31:0] r_inv_in;
    logic [15:0] r_rel_in;
    logic [30:0] r_amp;
    logic [15:0] r_rel_step;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op      <= i_opcode;
            r_voice   <= i_voice;
            r_step_in <= i_phase_step;
            r_len_in  <= i_note_length;
            r_inv_in  <= i_inverse_length;
            r_rel_in  <= i_release_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_amp      <= 31'd536870911;
            r_rel_step <= 16'd7;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_AMPLITUDE) r_amp <= i_cfg_data;
            else r_rel_step <= i_cfg_data[15:0];
        end
    end

    logic [XW-1:0] w_vext;
    logic [VW-1:0] w_opaddr;
    assign w_vext   = XW'(r_voice);
    assign w_opaddr = w_vext[VW-1:0];

    assign o_stat.op       = r_op;
    assign o_stat.voice_ok = (32'(r_voice) < 32'(NUM_VOICES));

    // Voice table with written flags; an unwritten voice reads as reset
    logic                  w_we;
    logic [VW-1:0]         w_waddr, w_raddr;
    t_voice                w_wdata;
    logic [RW-1:0]         w_rdata;
    logic [NUM_VOICES-1:0] r_vld;
    logic                  r_vq;
    t_voice                w_cur;

    assign w_we    = i_cmd.acc_wr || i_cmd.op_wr;
    assign w_waddr = i_cmd.acc_wr ? i_vidx : w_opaddr;
    assign w_raddr = i_cmd.rd_op ? w_opaddr : i_vidx;
    assign w_cur   = r_vq ? t_voice'(w_rdata) : VOICE_RST;

    pdtm_ram #(.WIDTH(RW), .DEPTH(NUM_VOICES)) u_voice_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(RW'(w_wdata)),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_we) begin
            r_vld[w_waddr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_vq <= r_vld[w_raddr];
    end

    // Stage 1: phase and envelope position
    t_voice          r_rec;
    logic            r_snd, r_rel;
    logic [31:0]     r_phase, r_x;
    logic [PW-1:0]   w_ph, w_xw;

    assign w_ph = PW'(w_cur.pos) * PW'(w_cur.step);
    assign w_xw = PW'(w_cur.pos) * PW'(w_cur.inv);

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_rec   <= w_cur;
            r_snd   <= w_cur.active || (w_cur.gain != 16'h0);
            r_rel   <= !w_cur.active && (w_cur.gain != 16'h0);
            r_phase <= w_ph[31:0];
            r_x     <= (|w_xw[PW-1:32]) ? 32'hFFFF_FFFF : w_xw[31:0];
        end
    end

    // Stage 2: table lookups
    logic signed [16:0] r_c;
    logic [30:0]        r_e;

    always_ff @(posedge i_clk) begin
        if (i_cmd.lut) begin
            r_c <= w_cos_rom[r_phase[31 -: TABLE_BITS]];
            r_e <= r_rel ? w_e20_rom[r_x[31 -: TABLE_BITS]]
                         : w_e14_rom[r_x[31 -: TABLE_BITS]];
        end
    end

    // Stages 3 to 5: magnitude products, each truncated
    logic [30:0] r_mag;
    logic        r_neg;
    logic [16:0] w_cabs;
    logic [47:0] w_p2;
    logic [61:0] w_p3;
    logic [46:0] w_p4;

    assign w_cabs = r_c[16] ? 17'(-r_c) : 17'(r_c);
    assign w_p2   = 48'(r_amp) * 48'(w_cabs);
    assign w_p3   = 62'(r_mag) * 62'(r_e);
    assign w_p4   = 47'(r_mag) * 47'(r_rec.gain);

    always_ff @(posedge i_clk) begin
        if (i_cmd.m2) begin
            r_mag <= w_p2[45:15];
            r_neg <= r_c[16];
        end else if (i_cmd.m3) begin
            r_mag <= w_p3[60:30];
        end else if (i_cmd.m4 && r_rel) begin
            r_mag <= w_p4[46:16];
        end
    end

    // Accumulate and build the written-back voice
    logic signed [31:0]   w_term;
    logic signed [AW-1:0] r_acc;
    t_voice               w_tick_rec, w_op_rec;
    logic [LENGTH_BITS-1:0] w_npos;
    logic [15:0]          w_ngain;

    assign w_term = r_neg ? -$signed({1'b0, r_mag}) : $signed({1'b0, r_mag});

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_acc) begin
            r_acc <= '0;
        end else if (i_cmd.acc_wr && r_snd) begin
            r_acc <= r_acc + AW'(w_term);
        end
    end

    always_comb begin
        w_npos  = r_snd ? r_rec.pos + LENGTH_BITS'(1) : r_rec.pos;
        w_ngain = r_rec.gain;
        if (r_rel) w_ngain = (r_rec.gain > r_rel_step) ? r_rec.gain - r_rel_step : 16'h0;
        w_tick_rec      = r_rec;
        w_tick_rec.pos  = w_npos;
        w_tick_rec.gain = w_ngain;
        if (w_npos >= r_rec.len) begin
            w_tick_rec.active = 1'b0;
            w_tick_rec.gain   = 16'h0;
            w_tick_rec.pos    = '0;
        end
    end

    always_comb begin
        w_op_rec     = w_cur;
        w_op_rec.pos = '0;
        unique case (r_op)
            OP_LOAD: begin
                w_op_rec.step   = r_step_in;
                w_op_rec.len    = LENGTH_BITS'(r_len_in);
                w_op_rec.inv    = r_inv_in;
                w_op_rec.active = 1'b0;
                w_op_rec.gain   = 16'h0;
            end
            OP_ON:  w_op_rec.active = 1'b1;
            OP_OFF: begin
                w_op_rec.active = 1'b0;
                w_op_rec.gain   = r_rel_in;
            end
            default: w_op_rec = w_cur;
        endcase
    end

    assign w_wdata = i_cmd.acc_wr ? w_tick_rec : w_op_rec;

    // Saturate the sum into the output register
    logic [AW-32:0] w_hi;
    logic           w_clip;
    assign w_hi   = r_acc[AW-1:31];
    assign w_clip = !((&w_hi) || !(|w_hi));

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_clipped <= w_clip;
            if (w_clip) o_sample <= r_acc[AW-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
            else o_sample <= r_acc[31:0];
        end
    end

endmodule

@@ test/polyphonic_decaying_tone_mixer_chk.sv @@
`timescale 1ns / 1ps

module polyphonic_decaying_tone_mixer_chk
    import pdtm_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    input  logic         i_s_tready,
    input  logic [1:0]   i_s_tuser,
    input  logic [111:0] i_s_tdata,
    input  logic         i_m_tvalid,
    input  logic         i_m_tready,
    input  logic [31:0]  i_m_tdata,
    input  logic         i_m_tuser,
    input  logic         i_cfg_valid,
    input  logic         i_cfg_ready,
    input  logic         i_cfg_index,
    input  logic [30:0]  i_cfg_data,
    output int           o_errors,
    output int           o_pending
);

    localparam int NV = 16;
    localparam int TB = 10;
    localparam int TS = 1 << TB;

    typedef struct packed {
        logic [31:0] sample;
        logic        clipped;
    } t_mix;

    // Lookup tables rebuilt here from their defining series
    int              cos_lut [TS];
    longint unsigned e14_lut [TS];
    longint unsigned e20_lut [TS];

    logic [30:0] amp;
    logic [15:0] rel_step;
    logic        act  [NV];
    logic [23:0] pos  [NV];
    logic [15:0] gain [NV];
    logic [31:0] stp  [NV];
    logic [23:0] len  [NV];
    logic [31:0] inv  [NV];

    t_mix mix_q[$];

    function automatic longint sat_q30(input longint v);
        if (v < 0) return 0;
        if (v > 64'sd1073741824) return 64'sd1073741824;
        return v;
    endfunction

    function automatic int qcos(input int j);
        longint unsigned a, a2, term;
        longint          s;
        a    = (longint'(j) * 64'd1686629713) >> (TB - 2);
        a2   = (a * a) >> 30;
        term = 64'd1 << 30;
        s    = 64'sd1 << 30;
        for (int n = 1; n <= 8; n++) begin
            term = ((term * a2) >> 30) / longint'((2 * n - 1) * (2 * n));
            s = (n % 2) ? s - longint'(term) : s + longint'(term);
        end
        s = sat_q30(s);
        return int'((s + 16384) >>> 15);
    endfunction

    function automatic longint unsigned decay(input int rate, input int k);
        longint unsigned t, term, v;
        longint          s;
        t    = (((longint'(rate) * k) << 30) >> TB) >> 6;
        term = 64'd1 << 30;
        s    = 64'sd1 << 30;
        for (int n = 1; n <= 10; n++) begin
            term = ((term * t) >> 30) / longint'(n);
            s = (n % 2) ? s - longint'(term) : s + longint'(term);
        end
        v = sat_q30(s);
        for (int n = 0; n < 6; n++) v = (v * v) >> 30;
        return v;
    endfunction

    // Contribution of one voice at its current position
    function automatic longint voice_out(input int v, input bit rel);
        logic [31:0]     ph;
        longint unsigned xw, mag, e;
        logic [31:0]     x;
        int              c;
        ph  = 32'(longint'(pos[v]) * longint'(stp[v]));
        xw  = longint'(pos[v]) * longint'(inv[v]);
        x   = (xw > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : xw[31:0];
        c   = cos_lut[ph >> (32 - TB)];
        e   = rel ? e20_lut[x >> (32 - TB)] : e14_lut[x >> (32 - TB)];
        mag = (c < 0) ? -c : c;
        mag = (longint'(amp) * mag) >> 15;
        mag = (mag * e) >> 30;
        if (rel) mag = (mag * gain[v]) >> 16;
        return (c < 0) ? -longint'(mag) : longint'(mag);
    endfunction

    // Apply one command; ticks produce one mixed sample
    task automatic apply_cmd(input logic [1:0] op, input logic [111:0] d);
        logic [3:0] vi;
        longint     acc;
        t_mix       r;
        vi = d[3:0];
        case (op)
            OP_LOAD: begin
                stp[vi] = d[35:4]; len[vi] = d[59:36]; inv[vi] = d[91:60];
                act[vi] = 1'b0; pos[vi] = '0; gain[vi] = '0;
            end
            OP_ON: begin
                act[vi] = 1'b1; pos[vi] = '0;
            end
            OP_OFF: begin
                act[vi] = 1'b0; pos[vi] = '0; gain[vi] = d[107:92];
            end
            default: begin
                acc = 0;
                for (int v = 0; v < NV; v++) begin
                    if (act[v]) begin
                        acc += voice_out(v, 0);
                        pos[v] = pos[v] + 24'd1;
                    end else if (gain[v] != 0) begin
                        acc += voice_out(v, 1);
                        pos[v] = pos[v] + 24'd1;
                        gain[v] = (gain[v] > rel_step) ? gain[v] - rel_step : 16'd0;
                    end
                    if (pos[v] >= len[v]) begin
                        act[v] = 1'b0; gain[v] = '0; pos[v] = '0;
                    end
                end
                r.clipped = 1'b1;
                if (acc > 64'sd2147483647) acc = 64'sd2147483647;
                else if (acc < -64'sd2147483648) acc = -64'sd2147483648;
                else r.clipped = 1'b0;
                r.sample = acc[31:0];
                mix_q.push_back(r);
            end
        endcase
    endtask

    initial begin
        for (int k = 0; k < TS; k++) begin
            int quad, rr;
            quad = k >> (TB - 2);
            rr   = k & (TS / 4 - 1);
            case (quad)
                0:       cos_lut[k] = qcos(rr);
                1:       cos_lut[k] = -qcos(TS / 4 - rr);
                2:       cos_lut[k] = -qcos(rr);
                default: cos_lut[k] = qcos(TS / 4 - rr);
            endcase
            e14_lut[k] = decay(14, k);
            e20_lut[k] = decay(20, k);
        end
    end

    assign o_pending = mix_q.size();

    // Watch every channel at the rising edge
    always @(posedge i_clk) begin
        t_mix want;
        if (!i_rst_n) begin
            amp = 31'd536870911;
            rel_step = 16'd7;
            for (int v = 0; v < NV; v++) begin
                act[v] = 1'b0; pos[v] = '0; gain[v] = '0;
                stp[v] = '0; len[v] = '1; inv[v] = '0;
            end
            mix_q.delete();
            o_errors = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_AMPLITUDE) amp = i_cfg_data;
                else rel_step = i_cfg_data[15:0];
            end
            if (i_m_tvalid && i_m_tready) begin
                if (mix_q.size() == 0) begin
                    $error("unexpected sample transaction 0x%08h", i_m_tdata);
                    o_errors++;
                end else begin
                    want = mix_q.pop_front();
                    if (i_m_tdata !== want.sample) begin
                        $error("sample: expected %0d, got %0d",
                               $signed(want.sample), $signed(i_m_tdata));
                        o_errors++;
                    end
                    if (i_m_tuser !== want.clipped) begin
                        $error("clipped: expected %0b, got %0b", want.clipped, i_m_tuser);
                        o_errors++;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) apply_cmd(i_s_tuser, i_s_tdata);
        end
    end

endmodule

@@ test/polyphonic_decaying_tone_mixer_tb.sv @@
`timescale 1ns / 1ps

module polyphonic_decaying_tone_mixer_tb;
    import pdtm_pkg::*;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_valid;
    logic         s_ready;
    logic [1:0]   s_user;
    logic [111:0] s_data;
    logic         m_valid;
    logic         m_ready;
    logic [31:0]  m_data;
    logic         m_user;
    logic         cfg_valid;
    logic         cfg_ready;
    logic         cfg_index;
    logic [30:0]  cfg_data;
    int           errors;
    int           pending;
    int           cycles;
    int           src_idle;
    int           snk_idle;

    polyphonic_decaying_tone_mixer dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_valid), .o_s_tready(s_ready),
        .i_s_tuser(s_user), .i_s_tdata(s_data),
        .o_m_tvalid(m_valid), .i_m_tready(m_ready),
        .o_m_tdata(m_data), .o_m_tuser(m_user),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    polyphonic_decaying_tone_mixer_chk chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_valid), .i_s_tready(s_ready),
        .i_s_tuser(s_user), .i_s_tdata(s_data),
        .i_m_tvalid(m_valid), .i_m_tready(m_ready),
        .i_m_tdata(m_data), .i_m_tuser(m_user),
        .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .o_errors(errors), .o_pending(pending)
    );

    initial begin
        i_clk = 0;
        forever #4 i_clk = ~i_clk;
    end

    // Watchdog
    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > 1500000) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // Receiver stalls
    always @(negedge i_clk) begin
        m_ready <= ($urandom_range(99) >= snk_idle);
    end

    // One command transaction, with random idle cycles ahead of it;
    // valid stays up after the handshake until the next call or a drain
    task automatic send(input logic [1:0] op, input logic [111:0] d);
        while ($urandom_range(99) < src_idle) begin
            s_valid <= 1'b0;
            @(negedge i_clk);
        end
        s_valid <= 1'b1;
        s_user  <= op;
        s_data  <= d;
        @(posedge i_clk);
        while (!s_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic logic [111:0] pack_cmd(input logic [3:0] v, input logic [31:0] st,
                                              input logic [23:0] ln, input logic [31:0] iv,
                                              input logic [15:0] rl);
        return {4'd0, rl, iv, ln, st, v};
    endfunction

    task automatic drain();
        s_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (150) @(negedge i_clk);
    endtask

    task automatic cfg_write(input logic idx, input logic [30:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // Random load with a length mostly short enough to finish notes
    task automatic rand_load(input logic [3:0] v);
        logic [23:0] ln;
        logic [31:0] iv;
        case ($urandom_range(9))
            0:       ln = 24'($urandom);
            1:       ln = '0;
            default: ln = 24'($urandom_range(60, 1));
        endcase
        iv = (ln != 0) ? 32'((64'd1 << 32) / ln) : 32'd0;
        if ($urandom_range(7) == 0) iv = $urandom;
        send(OP_LOAD, pack_cmd(v, $urandom, ln, iv, 16'($urandom)));
    endtask

    task automatic rand_phase(input int n);
        logic [1:0] op;
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(9))
                0:       op = OP_LOAD;
                1, 2:    op = OP_ON;
                3:       op = OP_OFF;
                default: op = OP_TICK;
            endcase
            if (op == OP_LOAD) rand_load(4'($urandom));
            else send(op, 112'({$urandom, $urandom, $urandom, $urandom}));
        end
    endtask

    initial begin
        i_rst_n   = 0;
        s_valid   = 0;
        s_user    = OP_TICK;
        s_data    = '0;
        m_ready   = 0;
        cfg_valid = 0;
        cfg_index = CFG_AMPLITUDE;
        cfg_data  = '0;
        src_idle  = 0;
        snk_idle  = 0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);

        // Directed: silence, extremes, overflow, zero length, release
        send(OP_TICK, '0);
        send(OP_ON, pack_cmd(4'd0, '0, '0, '0, '0));
        send(OP_TICK, '0);
        send(OP_LOAD, pack_cmd(4'd15, 32'hFFFF_FFFF, 24'hFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF));
        send(OP_ON, pack_cmd(4'd15, '0, '0, '0, '0));
        send(OP_LOAD, pack_cmd(4'd1, '0, 24'd0, '0, '0));
        send(OP_ON, pack_cmd(4'd1, '0, '0, '0, '0));
        send(OP_LOAD, pack_cmd(4'd2, 32'h0400_0000, 24'd8, 32'h2000_0000, 16'd0));
        send(OP_ON, pack_cmd(4'd2, '0, '0, '0, '0));
        repeat (3) send(OP_TICK, '1);
        send(OP_OFF, pack_cmd(4'd2, '0, '0, '0, 16'hFFFF));
        send(OP_OFF, pack_cmd(4'd3, '0, '0, '0, 16'd1));
        repeat (3) send(OP_TICK, '0);
        drain();
        cfg_write(CFG_AMPLITUDE, 31'h7FFF_FFFF);
        cfg_write(CFG_REL_STEP, 31'd65535);
        for (int v = 0; v < 16; v++) send(OP_ON, pack_cmd(4'(v), '0, '0, '0, '0));
        repeat (2) send(OP_TICK, '0);
        send(OP_OFF, pack_cmd(4'd15, '0, '0, '0, 16'd100));
        send(OP_TICK, '0);
        drain();

        // Random phases with shifting idle profiles and settings
        for (int ph = 0; ph < 6; ph++) begin
            src_idle = (ph < 2) ? 22 : (ph < 4) ? 68 : 0;
            snk_idle = (ph < 2) ? 68 : (ph < 4) ? 22 : 0;
            case (ph)
                0: cfg_write(CFG_AMPLITUDE, 31'd0);
                1: cfg_write(CFG_AMPLITUDE, 31'($urandom));
                2: cfg_write(CFG_REL_STEP, 31'd0);
                3: cfg_write(CFG_AMPLITUDE, 31'd536870911);
                4: cfg_write(CFG_REL_STEP, 31'($urandom_range(65535)));
                default: cfg_write(CFG_REL_STEP, 31'd7);
            endcase
            rand_phase(150);
            drain();
        end

        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

@@ polyphonic_decaying_tone_mixer.f @@
src/pdtm_pkg.sv
src/pdtm_ram.sv
src/pdtm_ctrl.sv
src/pdtm_dp.sv
src/polyphonic_decaying_tone_mixer.sv
test/polyphonic_decaying_tone_mixer_chk.sv
test/polyphonic_decaying_tone_mixer_tb.sv
